### hdl/tlf_pkg.sv
// Package for the text line folder: character codes, the split marker,
// the register reset value and the sequencer state type.
// No dependencies; imported by the top level, the output stage and the testbench.
`default_nettype none

package tlf_pkg;

    localparam int unsigned CFG_W     = 6;
    localparam int unsigned SPLIT_LEN = 7;

    localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd10;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EMIT
    } state_t;

    // One entry handed from the sequencer to the output stage.
    typedef struct packed {
        logic       valid;
        logic       from_mem;
        logic [7:0] ch;
        logic       last;
    } issue_t;

    // What the output stage reports back to the sequencer.
    typedef struct packed {
        logic space;
        logic stage_busy;
    } stage_status_t;

    function automatic logic [7:0] split_char(input logic [2:0] k);
        logic [7:0] c;
        unique case (k)
            3'd0:    c = 8'h5B; // '['
            3'd1:    c = 8'h73; // 's'
            3'd2:    c = 8'h70; // 'p'
            3'd3:    c = 8'h6C; // 'l'
            3'd4:    c = 8'h69; // 'i'
            3'd5:    c = 8'h74; // 't'
            3'd6:    c = 8'h5D; // ']'
            default: c = CH_NL;
        endcase
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

`default_nettype wire

### hdl/tlf_line_buffer.sv
// Circular line buffer memory: one write port and one registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module tlf_line_buffer #(
    parameter int unsigned PTR_W = 6
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [PTR_W-1:0] wr_addr,
    input  wire logic [7:0]       wr_data,
    input  wire logic             rd_en,
    input  wire logic [PTR_W-1:0] rd_addr,
    output logic      [7:0]       rd_data
);

    localparam int unsigned DEPTH = 2 ** PTR_W;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hdl/tlf_out_stage.sv
// Output pipeline: a stage that waits for the memory read data, then the
// output register that drives the result channel. Depends on tlf_pkg.
`default_nettype none

module tlf_out_stage
    import tlf_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire issue_t        issue,
    input  wire logic [7:0]    rd_data,
    output stage_status_t      status,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         char_out,
    output logic               last
);

    logic       st_valid_reg;
    logic       st_mem_reg;
    logic [7:0] st_char_reg;
    logic       st_last_reg;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       out_last_reg;
    logic       out_free;
    logic       st_take;

    assign out_free          = !out_valid_reg || out_ready;
    assign st_take           = st_valid_reg && out_free;
    assign status.space      = !st_valid_reg || st_take;
    assign status.stage_busy = st_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue.valid)
            begin
                st_valid_reg <= 1'b1;
            end
            else if (st_take)
            begin
                st_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= st_valid_reg;
            end
        end
    end

    // Read data changes only on an issue or, stage empty, on a search read,
    // so it still belongs to the entry in the stage at the edge it moves on.
    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            st_mem_reg  <= issue.from_mem;
            st_char_reg <= issue.ch;
            st_last_reg <= issue.last;
        end
        if (st_take)
        begin
            out_char_reg <= st_mem_reg ? rd_data : st_char_reg;
            out_last_reg <= st_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = out_char_reg;
    assign last      = out_last_reg;

`ifndef SYNTHESIS
    a_issue_has_space: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid |-> status.space)
        else $error("entry issued into a full output stage");
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid_reg && out_free && !issue.valid) |=> !st_valid_reg)
        else $error("output stage kept an entry that had moved on");
    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid_reg && out_free) |=> out_valid_reg)
        else $error("output register missed a transfer from the stage");
`endif

endmodule

`default_nettype wire

### hdl/text_line_folder.sv
// Text line folder top level: sequencer, blank search and emission control.
// Depends on tlf_pkg, tlf_line_buffer and tlf_out_stage.
//
// Usage. Characters arrive on the in channel (char_in, end_of_text) and the
// folded text leaves on the out channel (char_out, last), both valid/ready.
// last marks the final byte caused by one input transfer. fold_width is
// written through the cfg channel (cfg_data), which is always ready.
// Timing. An ordinary character that causes no fold leaves the sequencer
// idle. A fold first searches the buffer for the last blank, from the fold
// width down, one position at a time through the single memory read port
// and blank comparator, each position in a read and a check state. Emission
// then delivers one byte per cycle while the output stage has space: the
// bytes up to the fold, or all on a flush, plus up to eight more. The first
// byte of a flush passes the emit state, the stage and the output register.
// in_ready is high only while the sequencer is idle; the last bytes of an
// item may still drain while the next character is taken.
// Reset clears the fill count, the head pointer and the output channel and
// sets fold_width to 10. No clearing pass is needed.
// When the receiver stalls, the output register and one stage behind it hold
// their bytes and the sequencer stops issuing until space frees.
`default_nettype none

module text_line_folder
    import tlf_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       char_in,
    input  wire logic             end_of_text,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            char_out,
    output logic                  last
);

    localparam int unsigned PTR_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CNT_W = $clog2(MAX_WIDTH + 2);
    localparam int unsigned EK_W  = $clog2(MAX_WIDTH + SPLIT_LEN + 2);

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   width_reg;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [PTR_W-1:0]   em_base_reg, em_base_next;
    logic [EK_W-1:0]    em_k_reg, em_k_next;
    logic [CNT_W-1:0]   em_nbuf_reg, em_nbuf_next;
    logic               em_mark_reg, em_mark_next;
    logic               em_nl_reg, em_nl_next;

    logic [CFG_W-1:0]   w_clamp;
    logic [CNT_W-1:0]   w_eff;
    logic [CNT_W-1:0]   fill_inc;
    logic [EK_W-1:0]    em_total;
    logic [EK_W-1:0]    em_off;
    logic               in_xfer;
    logic               is_flush;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic [7:0]         rd_data;
    issue_t             issue;
    stage_status_t      status;

    // Widths of zero act as one, widths beyond MAX_WIDTH as MAX_WIDTH.
    always_comb
    begin
        priority if (width_reg == '0)
        begin
            w_clamp = CFG_W'(1);
        end
        else if (width_reg > CFG_W'(MAX_WIDTH))
        begin
            w_clamp = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = width_reg;
        end
    end

    assign w_eff     = CNT_W'(w_clamp);
    assign fill_inc  = fill_reg + CNT_W'(1);
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && in_ready;
    assign is_flush  = end_of_text || (char_in == CH_NL);
    assign em_total  = EK_W'(em_nbuf_reg)
                     + (em_mark_reg ? EK_W'(SPLIT_LEN) : '0)
                     + (em_nl_reg ? EK_W'(1) : '0);
    assign em_off    = em_k_reg - EK_W'(em_nbuf_reg);
    assign wr_en     = in_xfer && !is_flush;
    assign wr_addr   = head_reg + fill_reg[PTR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            width_reg <= WIDTH_RESET;
            head_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            if (cfg_valid && cfg_ready)
            begin
                width_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        em_base_reg  <= em_base_next;
        em_k_reg     <= em_k_next;
        em_nbuf_reg  <= em_nbuf_next;
        em_mark_reg  <= em_mark_next;
        em_nl_reg    <= em_nl_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        scan_idx_next = scan_idx_reg;
        em_base_next  = em_base_reg;
        em_k_next     = em_k_reg;
        em_nbuf_next  = em_nbuf_reg;
        em_mark_next  = em_mark_reg;
        em_nl_next    = em_nl_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        issue         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (is_flush)
                    begin
                        // An end of text with nothing buffered produces nothing.
                        if (!(end_of_text && (fill_reg == '0)))
                        begin
                            em_base_next = head_reg;
                            em_nbuf_next = fill_reg;
                            em_mark_next = 1'b0;
                            em_nl_next   = !end_of_text;
                            em_k_next    = '0;
                            state_next   = S_EMIT;
                        end
                        fill_next = '0;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                        if (fill_inc > w_eff)
                        begin
                            scan_idx_next = w_eff;
                            state_next    = S_SCAN_RD;
                        end
                    end
                end
            end

            S_SCAN_RD:
            begin
                // The read port is shared with the stage waiting on its data.
                if (!status.stage_busy)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg + scan_idx_reg[PTR_W-1:0];
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (is_blank(rd_data) || (scan_idx_reg == CNT_W'(1)))
                begin
                    em_base_next = head_reg;
                    em_nl_next   = 1'b1;
                    em_k_next    = '0;
                    state_next   = S_EMIT;
                    if (is_blank(rd_data))
                    begin
                        em_nbuf_next = scan_idx_reg;
                        em_mark_next = 1'b0;
                        head_next    = head_reg + scan_idx_reg[PTR_W-1:0];
                        fill_next    = fill_reg - scan_idx_reg;
                    end
                    else
                    begin
                        em_nbuf_next = w_eff;
                        em_mark_next = 1'b1;
                        head_next    = head_reg + w_eff[PTR_W-1:0];
                        fill_next    = fill_reg - w_eff;
                    end
                end
                else
                begin
                    scan_idx_next = scan_idx_reg - CNT_W'(1);
                    state_next    = S_SCAN_RD;
                end
            end

            S_EMIT:
            begin
                if (status.space)
                begin
                    issue.valid = 1'b1;
                    issue.last  = (em_k_reg == em_total - EK_W'(1));
                    priority if (em_k_reg < EK_W'(em_nbuf_reg))
                    begin
                        issue.from_mem = 1'b1;
                        rd_en          = 1'b1;
                        rd_addr        = em_base_reg + em_k_reg[PTR_W-1:0];
                    end
                    else if (em_mark_reg && (em_off < EK_W'(SPLIT_LEN)))
                    begin
                        issue.ch = split_char(em_off[2:0]);
                    end
                    else
                    begin
                        issue.ch = CH_NL;
                    end
                    em_k_next = em_k_reg + EK_W'(1);
                    if (issue.last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    tlf_line_buffer #(
        .PTR_W (PTR_W)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (char_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tlf_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .rd_data   (rd_data),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out),
        .last      (last)
    );

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (fill_reg <= CNT_W'(MAX_WIDTH)))
        else $error("line buffer holds more than its maximum between items");
    a_port_share: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("buffer written and read in the same cycle");
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_CHK) |->
            ((scan_idx_reg != '0) && (scan_idx_reg <= w_eff)))
        else $error("blank search outside positions one to the width");
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (em_k_reg < em_total))
        else $error("emission ran past the end of its run");
`endif

endmodule

`default_nettype wire

### test/text_line_folder_tb.sv
// Self-checking testbench for text_line_folder: a directed table followed by
// random text, with bursts of idling on both channels. Depends on tlf_pkg and
// on text_line_folder; the expected output is built by a folding predictor.
module text_line_folder_tb
    import tlf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_W        = 32;
    // A fold searches the buffer column by column before any byte leaves.
    localparam int unsigned SETTLE_CYCLES = 2 * MAX_W + 16;
    localparam int unsigned DRAIN_CYCLES  = 100;
    localparam int          RUN_LIMIT     = 400000;
    localparam int          PHASES        = 6;
    localparam int          PHASE_ITEMS   = 50;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_byte_t;

    typedef enum logic {
        ROW_CHAR,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] val;
        logic       eot;
        logic       typed;
    } stim_row_t;

    logic             clk;
    logic             rst_n       = 1'b0;
    logic             cfg_valid   = 1'b0;
    logic [CFG_W-1:0] cfg_data    = '0;
    logic             in_valid    = 1'b0;
    logic [7:0]       char_in     = 8'h00;
    logic             end_of_text = 1'b0;
    logic             out_ready   = 1'b0;
    logic             cfg_ready;
    logic             in_ready;
    logic             out_valid;
    logic [7:0]       char_out;
    logic             last;

    // Predictor state: a copy of the line buffer, its fill and the width.
    logic [7:0]       line_mem [0:MAX_W];
    int unsigned      fill      = 0;
    logic [CFG_W-1:0] width_reg = WIDTH_RESET;
    string            split_mark = "[split]";

    out_byte_t        fold_out [$];
    out_byte_t        exp_q [$];
    stim_row_t        rows [$];
    string            row_want [$];

    bit               calm        = 1'b0;
    int               in_idle_pct = 20;
    int               out_stall_pct = 15;
    int               stall_left  = 0;
    int               cycle_count = 0;
    int               error_count = 0;
    int               items_sent  = 0;
    int               bytes_seen  = 0;
    int               cfg_writes  = 0;
    int               blank_folds = 0;
    int               split_folds = 0;

    text_line_folder #(
        .MAX_WIDTH (MAX_W)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_in     (char_in),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_out    (char_out),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic void add_byte(input logic [7:0] c);
        out_byte_t b;
        b.ch   = c;
        b.last = 1'b0;
        fold_out.push_back(b);
    endfunction

    // Works out the bytes that one character transfer produces and updates the
    // predicted buffer. At most one fold happens per transfer.
    function automatic void fold_predict(input logic [7:0] c, input logic eot);
        int unsigned w;
        int unsigned p;
        int unsigned cut;
        out_byte_t   lb;
        fold_out.delete();
        if (eot || c == CH_NL)
        begin
            for (int unsigned i = 0; i < fill; i++)
                add_byte(line_mem[i]);
            if (!eot)
                add_byte(CH_NL);
            fill = 0;
        end
        else
        begin
            w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
            line_mem[fill] = c;
            fill++;
            if (fill > w)
            begin
                // The blank nearest the fold column wins; column zero never counts.
                p = 0;
                for (int unsigned i = w; i > 0; i--)
                    if (p == 0 && (line_mem[i] == CH_SPACE || line_mem[i] == CH_TAB))
                        p = i;
                if (p != 0)
                begin
                    for (int unsigned i = 0; i < p; i++)
                        add_byte(line_mem[i]);
                    cut = p;
                    blank_folds++;
                end
                else
                begin
                    for (int unsigned i = 0; i < w; i++)
                        add_byte(line_mem[i]);
                    for (int k = 0; k < split_mark.len(); k++)
                        add_byte(split_mark[k]);
                    cut = w;
                    split_folds++;
                end
                add_byte(CH_NL);
                for (int unsigned i = 0; i < fill - cut; i++)
                    line_mem[i] = line_mem[i + cut];
                fill -= cut;
            end
        end
        if (fold_out.size() > 0)
        begin
            lb = fold_out.pop_back();
            lb.last = 1'b1;
            fold_out.push_back(lb);
        end
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic [7:0] val,
                                    input logic eot, input logic typed, input string want);
        stim_row_t r;
        r.kind  = kind;
        r.val   = val;
        r.eot   = eot;
        r.typed = typed;
        rows.push_back(r);
        row_want.push_back(want);
    endfunction

    // Offers one character, waits for its transfer and files what it should produce.
    // Where a hand-written result is given it replaces the predicted one.
    task automatic send_item(input logic [7:0] c, input logic eot,
                             input logic typed, input string want);
        out_byte_t ob;
        in_valid    <= 1'b1;
        char_in     <= c;
        end_of_text <= eot;
        do @(posedge clk); while (!in_ready);
        fold_predict(c, eot);
        if (typed)
        begin
            for (int k = 0; k < want.len(); k++)
            begin
                ob.ch   = want[k];
                ob.last = (k == want.len() - 1);
                exp_q.push_back(ob);
            end
        end
        else
        begin
            foreach (fold_out[k])
                exp_q.push_back(fold_out[k]);
        end
        items_sent++;
        if (items_sent % 32 == 0)
        begin
            case ($urandom_range(0, 2))
                0:       in_idle_pct = 0;
                1:       in_idle_pct = 20;
                default: in_idle_pct = 50;
            endcase
        end
        if (!calm && $urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // The width is only changed once the block has drained and gone quiet.
    task automatic write_width(input logic [CFG_W-1:0] v);
        in_valid <= 1'b0;
        while (exp_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_reg = v;
        cfg_writes++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Timed out with %0d bytes still expected.", exp_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver back-pressure: random bursts of stalls, their rate changing now and then.
    always @(posedge clk)
    begin
        if (cycle_count % 64 == 0)
        begin
            case ($urandom_range(0, 2))
                0:       out_stall_pct = 0;
                1:       out_stall_pct = 15;
                default: out_stall_pct = 40;
            endcase
        end
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!calm && rst_n && $urandom_range(0, 99) < out_stall_pct)
        begin
            stall_left <= $urandom_range(0, 3);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_out
        out_byte_t want_b;
        if (rst_n && out_valid && out_ready)
        begin
            bytes_seen++;
            if (exp_q.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h with last %0b",
                                          char_out, last));
            else
            begin
                want_b = exp_q.pop_front();
                if (char_out !== want_b.ch)
                    report_mismatch($sformatf("char_out %02h, expected %02h",
                                              char_out, want_b.ch));
                if (last !== want_b.last)
                    report_mismatch($sformatf("last %0b on byte %02h, expected %0b",
                                              last, want_b.ch, want_b.last));
            end
        end
    end

    initial
    begin
        logic [7:0] c;
        logic       eot;
        int         r;
        int         directed;
        logic [5:0] phase_w [PHASES];
        int         blank_pct [PHASES];

        // Reset state: empty flush, newline alone, byte extremes.
        add_row(ROW_CHAR, CH_NL, 1'b1, 1'b1, "");
        add_row(ROW_CHAR, CH_NL, 1'b0, 1'b1, "\n");
        add_row(ROW_CHAR, 8'h00, 1'b0, 1'b1, "");
        add_row(ROW_CHAR, 8'hFF, 1'b0, 1'b1, "");
        add_row(ROW_CHAR, 8'h00, 1'b1, 1'b0, "");
        // Width one: forced split, blank folds, a blank in column zero, exact fit.
        add_row(ROW_CFG, 8'd1, 1'b0, 1'b0, "");
        add_row(ROW_CHAR, "a", 1'b0, 1'b1, "");
        add_row(ROW_CHAR, "b", 1'b0, 1'b1, "a[split]\n");
        add_row(ROW_CHAR, " ", 1'b0, 1'b1, "b\n");
        add_row(ROW_CHAR, " ", 1'b0, 1'b1, " \n");
        add_row(ROW_CHAR, "x", 1'b0, 1'b1, " [split]\n");
        add_row(ROW_CHAR, CH_NL, 1'b0, 1'b1, "x\n");
        // Width zero behaves as one; the tab counts as a blank.
        add_row(ROW_CFG, 8'd0, 1'b0, 1'b0, "");
        add_row(ROW_CHAR, "c", 1'b0, 1'b1, "");
        add_row(ROW_CHAR, CH_TAB, 1'b0, 1'b1, "c\n");
        add_row(ROW_CHAR, 8'hFF, 1'b1, 1'b1, "\t");
        // Fill four columns, then drop the width under the buffered line.
        add_row(ROW_CFG, 8'd4, 1'b0, 1'b0, "");
        add_row(ROW_CHAR, "a", 1'b0, 1'b1, "");
        add_row(ROW_CHAR, "b", 1'b0, 1'b1, "");
        add_row(ROW_CHAR, " ", 1'b0, 1'b1, "");
        add_row(ROW_CHAR, "c", 1'b0, 1'b1, "");
        add_row(ROW_CFG, 8'd1, 1'b0, 1'b0, "");
        add_row(ROW_CHAR, "d", 1'b0, 1'b1, "a[split]\n");
        add_row(ROW_CHAR, "e", 1'b0, 1'b1, "b\n");
        add_row(ROW_CHAR, CH_NL, 1'b0, 1'b1, " cde\n");
        // Largest register value is clamped to the maximum width.
        add_row(ROW_CFG, 8'd63, 1'b0, 1'b0, "");
        add_row(ROW_CHAR, "z", 1'b0, 1'b0, "");
        add_row(ROW_CHAR, 8'h00, 1'b1, 1'b0, "");

        phase_w[0] = 6'd32;  blank_pct[0] = 25;
        phase_w[1] = 6'd0;   blank_pct[1] = 3;
        phase_w[2] = 6'd33;  blank_pct[2] = 15;
        phase_w[3] = 6'($urandom_range(2, 31)); blank_pct[3] = 30;
        phase_w[4] = 6'd63;  blank_pct[4] = 8;
        phase_w[5] = 6'($urandom_range(1, 12)); blank_pct[5] = 20;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_width(rows[i].val[CFG_W-1:0]);
            else
                send_item(rows[i].val, rows[i].eot, rows[i].typed, row_want[i]);
        end
        directed = items_sent;

        // Random text: mostly words and blanks, some line ends, the rest any byte.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_width(phase_w[ph]);
            if (ph == PHASES - 1)
                calm = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r   = $urandom_range(0, 99);
                eot = 1'b0;
                if (r < 2)
                begin
                    eot = 1'b1;
                    c   = 8'($urandom);
                end
                else if (r < 7)
                    c = CH_NL;
                else if (r < 7 + blank_pct[ph])
                    c = ($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE;
                else if (r < 95)
                    c = 8'($urandom_range(8'h21, 8'h7E));
                else
                    c = 8'($urandom_range(0, 255));
                send_item(c, eot, 1'b0, "");
            end
        end

        in_valid <= 1'b0;
        while (exp_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters (%0d from the table) under %0d width settings; %0d bytes checked.",
                 items_sent, directed, cfg_writes, bytes_seen);
        $display("Folds predicted: %0d at a blank, %0d forced splits.", blank_folds, split_folds);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
hdl/tlf_pkg.sv
hdl/tlf_line_buffer.sv
hdl/tlf_out_stage.sv
hdl/text_line_folder.sv
test/text_line_folder_tb.sv
